// File: hdl/fba_pkg.sv
// shared types and constants for the first-fit block allocator
`default_nettype none
package fba_pkg;
  localparam int POOL_BYTES = 262144;
  localparam int MAX_BLOCKS = 64;
  localparam int DEPTH      = MAX_BLOCKS + 2;
  localparam int AW         = 19;
  localparam int EW         = AW + 1;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_REALLOC = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  localparam logic [1:0] ST_GIVEN = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_SPACE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic          has_block;
    logic [AW-1:0] block_offset;
    logic [AW-1:0] request_bytes;
  } in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] result_offset;
    logic          moved;
    logic [AW-1:0] copy_bytes;
  } out_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SIZE,
    CMD_DEL,
    CMD_INS
  } cmd_t;

  typedef struct packed {
    cmd_t kind;
    logic sel;
    logic ge;
  } cell_ctl_t;
endpackage
`default_nettype wire

// File: hdl/fba_cell.sv
// one table entry of the allocator, shifting with its neighbors
`default_nettype none
module fba_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  fba_pkg::entry_t         init,
  input  fba_pkg::cell_ctl_t      ctl,
  input  fba_pkg::entry_t         new_ent,
  input  fba_pkg::entry_t         left,
  input  fba_pkg::entry_t         right,
  input  wire [fba_pkg::AW-1:0]   key_off,
  input  wire [fba_pkg::AW-1:0]   key_req,
  input  wire                     en_hit,
  input  wire                     en_fit,
  output fba_pkg::entry_t         ent,
  output logic [fba_pkg::EW-1:0]  ent_end,
  output logic                    hit,
  output logic                    fit
);
  import fba_pkg::*;

  entry_t        ent_r;
  entry_t        ent_nxt;
  logic [EW-1:0] left_end;
  logic [EW-1:0] gap;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.kind)
      CMD_SIZE: begin
        if (ctl.sel) ent_nxt.size = new_ent.size;
      end
      CMD_DEL: begin
        if (ctl.ge) ent_nxt = right;
      end
      CMD_INS: begin
        if (ctl.sel) ent_nxt = new_ent;
        else if (ctl.ge) ent_nxt = left;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= init;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign left_end = {1'b0, left.start} + {1'b0, left.size};
  assign gap      = ({1'b0, ent_r.start} > left_end) ? ({1'b0, ent_r.start} - left_end)
                                                     : '0;
  assign ent      = ent_r;
  assign ent_end  = {1'b0, ent_r.start} + {1'b0, ent_r.size};
  assign hit      = en_hit && (ent_r.start == key_off);
  assign fit      = en_fit && (gap >= {1'b0, key_req});
endmodule
`default_nettype wire

// File: hdl/first_fit_block_allocator_top.sv
// first-fit allocator top: control sequencer over a row of table cells
//   channel | ports                    | beat
//   request | start, busy, in_item     | start high while busy low
//   result  | out_strobe, out_item     | out_strobe high for one cycle
// an item runs the find and decide steps of the sequencer for free, zero size or in-place realloc,
// and the fit-scan and place steps after them when a gap search runs
// one item at a time; busy stays high until its result beat is issued
// reset loads the two sentinels at once, no clearing pass
// the receiver cannot stall, results are never held
`default_nettype none
module first_fit_block_allocator_top (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  fba_pkg::in_t   in_item,
  output logic           out_strobe,
  output fba_pkg::out_t  out_item
);
  import fba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_DEC,
    S_FIT,
    S_PLACE
  } state_t;

  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [AW-1:0]     old_r, old_nxt;
  logic              mv_r, mv_nxt;
  logic [DEPTH-1:0]  occ_r, occ_nxt;
  logic [DEPTH-1:0]  hit_r, hit_nxt;
  logic [DEPTH-1:0]  fit_r, fit_nxt;
  out_t              out_r, out_nxt;
  logic              strobe_r, strobe_nxt;

  entry_t            ent     [DEPTH];
  logic [EW-1:0]     ent_end [DEPTH];
  entry_t            init    [DEPTH];
  entry_t            lft     [DEPTH];
  entry_t            rgt     [DEPTH];
  cell_ctl_t         ctl     [DEPTH];
  logic [DEPTH-1:0]  hit_v, fit_v, en_hit, en_fit;

  logic [DEPTH-1:0]  hit_oh, hit_ge, nxt_oh, fit_oh, fit_ge, prv_oh;
  logic [DEPTH-1:0]  sel_v, ge_v;
  cmd_t              cmd;
  entry_t            new_ent;
  logic [AW-1:0]     sel_size, nxt_start, prv_size;
  logic [EW-1:0]     prv_end, room;
  logic              found;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign init[g].start = (g == 1) ? AW'(POOL_BYTES) : '0;
      assign init[g].size  = '0;
      assign lft[g]        = (g == 0) ? entry_t'('0) : ent[(g == 0) ? 0 : g - 1];
      assign rgt[g]        = (g == DEPTH - 1) ? entry_t'('0)
                                              : ent[(g == DEPTH - 1) ? g : g + 1];
      assign en_hit[g]     = (g == DEPTH - 1) ? 1'b0
                                              : occ_r[(g == DEPTH - 1) ? g : g + 1];
      assign en_fit[g]     = (g == 0) ? 1'b0 : occ_r[g];
      assign ctl[g].kind   = cmd;
      assign ctl[g].sel    = sel_v[g];
      assign ctl[g].ge     = ge_v[g];
      fba_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .init    (init[g]),
        .ctl     (ctl[g]),
        .new_ent (new_ent),
        .left    (lft[g]),
        .right   (rgt[g]),
        .key_off (req_r.block_offset),
        .key_req (req_r.request_bytes),
        .en_hit  (en_hit[g]),
        .en_fit  (en_fit[g]),
        .ent     (ent[g]),
        .ent_end (ent_end[g]),
        .hit     (hit_v[g]),
        .fit     (fit_v[g])
      );
    end
  endgenerate

  assign hit_oh = hit_r & (~hit_r + DEPTH'(1));
  assign hit_ge = ~(hit_oh - DEPTH'(1));
  assign nxt_oh = hit_oh << 1;
  assign fit_oh = fit_r & (~fit_r + DEPTH'(1));
  assign fit_ge = ~(fit_oh - DEPTH'(1));
  assign prv_oh = fit_oh >> 1;
  assign found  = req_r.has_block && (|hit_r);

  always_comb begin
    sel_size  = '0;
    nxt_start = '0;
    prv_size  = '0;
    prv_end   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_size  = sel_size  | (ent[i].size  & {AW{hit_oh[i]}});
      nxt_start = nxt_start | (ent[i].start & {AW{nxt_oh[i]}});
      prv_size  = prv_size  | (ent[i].size  & {AW{prv_oh[i]}});
      prv_end   = prv_end   | (ent_end[i]   & {EW{prv_oh[i]}});
    end
  end

  assign room = {1'b0, nxt_start} - {1'b0, req_r.block_offset};

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    old_nxt     = old_r;
    mv_nxt      = mv_r;
    occ_nxt     = occ_r;
    hit_nxt     = hit_r;
    fit_nxt     = fit_r;
    out_nxt     = out_r;
    strobe_nxt  = 1'b0;
    cmd         = CMD_NONE;
    sel_v       = '0;
    ge_v        = '0;
    new_ent     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          mv_nxt    = 1'b0;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        hit_nxt   = hit_v;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        out_nxt = '0;
        out_nxt.status = ST_NONE;
        if (req_r.op == OP_ALLOC || (req_r.op == OP_REALLOC && !found)) begin
          if (req_r.request_bytes == '0) begin
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt  = S_FIT;
          end
        end else if (req_r.op == OP_REALLOC &&
                     (req_r.request_bytes == '0 ||
                      room < {1'b0, req_r.request_bytes})) begin
          if (hit_oh[0]) begin
            cmd   = CMD_SIZE;
            sel_v = hit_oh;
          end else begin
            cmd     = CMD_DEL;
            ge_v    = hit_ge;
            occ_nxt = occ_r >> 1;
          end
          if (req_r.request_bytes == '0) begin
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            old_nxt   = sel_size;
            mv_nxt    = 1'b1;
            state_nxt = S_FIT;
          end
        end else if (req_r.op == OP_REALLOC) begin
          cmd          = CMD_SIZE;
          sel_v        = hit_oh;
          new_ent.size = req_r.request_bytes;
          out_nxt.status        = ST_GIVEN;
          out_nxt.result_offset = req_r.block_offset;
          strobe_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          if (found) begin
            if (hit_oh[0]) begin
              cmd   = CMD_SIZE;
              sel_v = hit_oh;
            end else begin
              cmd     = CMD_DEL;
              ge_v    = hit_ge;
              occ_nxt = occ_r >> 1;
            end
          end
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIT: begin
        fit_nxt   = fit_v;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        out_nxt    = '0;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (fit_r == '0) begin
          out_nxt.status = ST_SPACE;
        end else if (prv_size != '0 && occ_r[DEPTH-1]) begin
          out_nxt.status = ST_FULL;
        end else begin
          new_ent.start = prv_end[AW-1:0];
          new_ent.size  = req_r.request_bytes;
          if (prv_size == '0) begin
            cmd   = CMD_SIZE;
            sel_v = prv_oh;
          end else begin
            cmd     = CMD_INS;
            sel_v   = fit_oh;
            ge_v    = fit_ge;
            occ_nxt = {occ_r[DEPTH-2:0], 1'b1};
          end
          out_nxt.status        = ST_GIVEN;
          out_nxt.result_offset = prv_end[AW-1:0];
          out_nxt.moved         = mv_r;
          if (mv_r) begin
            out_nxt.copy_bytes = (req_r.request_bytes < old_r) ? req_r.request_bytes : old_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= DEPTH'(3);
      strobe_r <= 1'b0;
      mv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
      mv_r     <= mv_nxt;
    end
    req_r <= req_nxt;
    old_r <= old_nxt;
    hit_r <= hit_nxt;
    fit_r <= fit_nxt;
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;
endmodule
`default_nettype wire
